// ===== design/b64sd_pkg.sv =====
package b64sd_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;

  localparam logic [7:0] LO_A_OFFSET = 8'd26;
  localparam logic [7:0] ZERO_OFFSET = 8'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  localparam logic [2:0] PEND_0 = 3'd0;
  localparam logic [2:0] PEND_2 = 3'd2;
  localparam logic [2:0] PEND_4 = 3'd4;
  localparam logic [2:0] PEND_6 = 3'd6;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       last;
    logic       ok;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_DATA,
    KIND_PAD
  } char_kind_t;

  typedef struct packed {
    char_kind_t kind;
    logic [5:0] sextet;
    logic       eom;
  } cls_item_t;

endpackage

// ===== design/base64_stream_decoder_unit.sv =====
// Path: an accepted item is written into the queue and then popped into the output
// register, from which its result can be taken; it waits longer when the queue holds
// earlier items or the output stalls.
// Throughput: one item per cycle while the output is not stalled.
// Characters that give no result are still popped from the queue by the back end.
// Reset: synchronous, active low; clears the queue, the decoder state and the output valid.
module base64_stream_decoder_unit #(
  parameter int QUEUE_DEPTH = b64sd_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  b64sd_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output b64sd_pkg::out_item_t out_item
);

  logic                 q_full;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_valid;
  b64sd_pkg::cls_item_t push_item;
  b64sd_pkg::cls_item_t q_item;

  b64sd_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  b64sd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  b64sd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  // A result without a byte exists only to mark the end of a message.
  a_empty_result_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.byte_valid |-> out_item.last)
    else $error("result with neither byte nor last");

  a_ok_only_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.ok |-> out_item.last)
    else $error("ok set on a result that is not last");

  a_no_byte_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.byte_valid |-> out_item.data_byte == 8'd0)
    else $error("data byte not zero without byte_valid");

  a_queue_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_ready && !q_push)
    else $error("item taken while the queue is full");
`endif

endmodule

// ===== design/b64sd_front.sv =====
module b64sd_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  b64sd_pkg::in_item_t  in_item,
  input  logic                 q_full,
  output logic                 q_push,
  output b64sd_pkg::cls_item_t q_item
);

  logic [7:0] c;

  assign c        = in_item.in_char;
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.eom    = in_item.end_of_message;
    q_item.kind   = b64sd_pkg::KIND_SKIP;
    q_item.sextet = '0;
    if (c == b64sd_pkg::CHAR_SPACE ||
        (c >= b64sd_pkg::CHAR_TAB && c <= b64sd_pkg::CHAR_CR)) begin
      q_item.kind = b64sd_pkg::KIND_SKIP;
    end else if (c >= b64sd_pkg::CHAR_UP_A && c <= b64sd_pkg::CHAR_UP_Z) begin
      q_item.kind   = b64sd_pkg::KIND_DATA;
      q_item.sextet = 6'(c - b64sd_pkg::CHAR_UP_A);
    end else if (c >= b64sd_pkg::CHAR_LO_A && c <= b64sd_pkg::CHAR_LO_Z) begin
      q_item.kind   = b64sd_pkg::KIND_DATA;
      q_item.sextet = 6'(c - b64sd_pkg::CHAR_LO_A + b64sd_pkg::LO_A_OFFSET);
    end else if (c >= b64sd_pkg::CHAR_ZERO && c <= b64sd_pkg::CHAR_NINE) begin
      q_item.kind   = b64sd_pkg::KIND_DATA;
      q_item.sextet = 6'(c - b64sd_pkg::CHAR_ZERO + b64sd_pkg::ZERO_OFFSET);
    end else if (c == b64sd_pkg::CHAR_PLUS) begin
      q_item.kind   = b64sd_pkg::KIND_DATA;
      q_item.sextet = b64sd_pkg::SEXTET_PLUS;
    end else if (c == b64sd_pkg::CHAR_SLASH) begin
      q_item.kind   = b64sd_pkg::KIND_DATA;
      q_item.sextet = b64sd_pkg::SEXTET_SLASH;
    end else if (c == b64sd_pkg::CHAR_PAD) begin
      q_item.kind = b64sd_pkg::KIND_PAD;
    end
  end

endmodule

// ===== design/b64sd_fifo.sv =====
module b64sd_fifo #(
  parameter int DEPTH = b64sd_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  b64sd_pkg::cls_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 q_valid,
  output b64sd_pkg::cls_item_t q_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  b64sd_pkg::cls_item_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== design/b64sd_back.sv =====
module b64sd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  b64sd_pkg::cls_item_t q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output b64sd_pkg::out_item_t out_item
);

  logic [5:0] acc_r, acc_nxt;
  logic [2:0] pend_r, pend_nxt;
  logic       pad_r, pad_nxt;
  logic       any_r, any_nxt;
  logic       out_valid_r, out_valid_nxt;
  b64sd_pkg::out_item_t out_item_r, out_item_nxt;

  logic       have_byte;
  logic [7:0] byte_val;
  logic [5:0] d;

  assign d         = q_item.sextet;
  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    acc_nxt       = acc_r;
    pend_nxt      = pend_r;
    pad_nxt       = pad_r;
    any_nxt       = any_r;
    have_byte     = 1'b0;
    byte_val      = '0;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (q_pop) begin
      if (!pad_r && q_item.kind == b64sd_pkg::KIND_DATA) begin
        case (pend_r)
          b64sd_pkg::PEND_2: begin
            have_byte = 1'b1;
            byte_val  = {acc_r[1:0], d};
            acc_nxt   = '0;
            pend_nxt  = b64sd_pkg::PEND_0;
          end
          b64sd_pkg::PEND_4: begin
            have_byte = 1'b1;
            byte_val  = {acc_r[3:0], d[5:2]};
            acc_nxt   = {4'd0, d[1:0]};
            pend_nxt  = b64sd_pkg::PEND_2;
          end
          b64sd_pkg::PEND_6: begin
            have_byte = 1'b1;
            byte_val  = {acc_r[5:0], d[5:4]};
            acc_nxt   = {2'd0, d[3:0]};
            pend_nxt  = b64sd_pkg::PEND_4;
          end
          default: begin
            acc_nxt  = d;
            pend_nxt = b64sd_pkg::PEND_6;
          end
        endcase
        if (have_byte) begin
          any_nxt = 1'b1;
        end
      end else if (!pad_r && q_item.kind == b64sd_pkg::KIND_PAD) begin
        pad_nxt = 1'b1;
      end

      out_valid_nxt           = have_byte || q_item.eom;
      out_item_nxt.byte_valid = have_byte;
      out_item_nxt.data_byte  = byte_val;
      out_item_nxt.last       = q_item.eom;
      out_item_nxt.ok         = q_item.eom && (any_r || have_byte);

      // The end of a message puts the decoder back in its reset state.
      if (q_item.eom) begin
        acc_nxt  = '0;
        pend_nxt = b64sd_pkg::PEND_0;
        pad_nxt  = 1'b0;
        any_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      pend_r      <= b64sd_pkg::PEND_0;
      pad_r       <= 1'b0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      pend_r      <= pend_nxt;
      pad_r       <= pad_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

class decode_scoreboard;
  logic [5:0]             leftover_bits;
  int unsigned            leftover_count;
  bit                     pad_seen;
  bit                     byte_seen;
  b64sd_pkg::out_item_t   pending_results[$];
  int unsigned            mismatches;

  function new();
    mismatches = 0;
    restart_message();
  endfunction

  function void restart_message();
    leftover_bits  = '0;
    leftover_count = 0;
    pad_seen       = 1'b0;
    byte_seen      = 1'b0;
  endfunction

  function bit is_blank(logic [7:0] c);
    return c == b64sd_pkg::CHAR_SPACE ||
           (c >= b64sd_pkg::CHAR_TAB && c <= b64sd_pkg::CHAR_CR);
  endfunction

  // Six-bit value of an alphabet character, or -1 for any other byte.
  function int sextet_of_char(logic [7:0] c);
    if (c >= b64sd_pkg::CHAR_UP_A && c <= b64sd_pkg::CHAR_UP_Z)
      return int'(c - b64sd_pkg::CHAR_UP_A);
    if (c >= b64sd_pkg::CHAR_LO_A && c <= b64sd_pkg::CHAR_LO_Z)
      return int'(c - b64sd_pkg::CHAR_LO_A) + int'(b64sd_pkg::LO_A_OFFSET);
    if (c >= b64sd_pkg::CHAR_ZERO && c <= b64sd_pkg::CHAR_NINE)
      return int'(c - b64sd_pkg::CHAR_ZERO) + int'(b64sd_pkg::ZERO_OFFSET);
    if (c == b64sd_pkg::CHAR_PLUS) return int'(b64sd_pkg::SEXTET_PLUS);
    if (c == b64sd_pkg::CHAR_SLASH) return int'(b64sd_pkg::SEXTET_SLASH);
    return -1;
  endfunction

  // Advances the decoder by one accepted item and queues the result it gives.
  function void note_char(b64sd_pkg::in_item_t it);
    logic [11:0]          joined;
    int                   sextet;
    int                   rem;
    bit                   have_byte;
    logic [7:0]           data;
    b64sd_pkg::out_item_t want;
    have_byte = 1'b0;
    data      = '0;
    if (!pad_seen && !is_blank(it.in_char)) begin
      sextet = sextet_of_char(it.in_char);
      if (sextet >= 0) begin
        joined = {leftover_bits, sextet[5:0]};
        if (leftover_count + 6 >= 8) begin
          rem            = int'(leftover_count) - 2;
          data           = 8'(joined >> rem);
          leftover_bits  = joined[5:0] & 6'((1 << rem) - 1);
          leftover_count = rem;
          have_byte      = 1'b1;
          byte_seen      = 1'b1;
        end else begin
          leftover_bits  = joined[5:0];
          leftover_count = leftover_count + 6;
        end
      end else if (it.in_char == b64sd_pkg::CHAR_PAD) begin
        pad_seen = 1'b1;
      end
    end
    if (have_byte || it.end_of_message) begin
      want.byte_valid = have_byte;
      want.data_byte  = data;
      want.last       = it.end_of_message;
      want.ok         = it.end_of_message && byte_seen;
      pending_results = {pending_results, want};
    end
    if (it.end_of_message) restart_message();
  endfunction

  function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, name, want_v, got_v);
    end
  endfunction

  function void check_result(b64sd_pkg::out_item_t got);
    b64sd_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      $display("%0t: result expected none, got %h", $time, got);
      return;
    end
    want = pending_results.pop_front();
    compare_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
    compare_field("data_byte", want.data_byte, got.data_byte);
    compare_field("last", 8'(want.last), 8'(got.last));
    compare_field("ok", 8'(want.ok), 8'(got.ok));
  endfunction
endclass

module tb_top;
  localparam int RANDOM_ITEMS = 1450;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  b64sd_pkg::in_item_t  in_item;
  logic                 out_valid;
  logic                 out_ready;
  b64sd_pkg::out_item_t out_item;

  decode_scoreboard sb;
  int unsigned      in_gap_max;
  int unsigned      out_stall_max;
  int unsigned      sent_items;
  int unsigned      cycle_count;
  logic [7:0]       msg_chars[$];

  base64_stream_decoder_unit i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_char(input logic [7:0] c, input bit eom);
    b64sd_pkg::in_item_t it;
    int unsigned         gap;
    it.in_char        = c;
    it.end_of_message = eom;
    gap = $urandom_range(in_gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_char(it);
    sent_items++;
  endtask

  task automatic send_message();
    foreach (msg_chars[i]) send_char(msg_chars[i], i == msg_chars.size() - 1);
  endtask

  function automatic logic [7:0] char_of_sextet(logic [5:0] v);
    if (v < 26) return b64sd_pkg::CHAR_UP_A + v;
    if (v < 52) return b64sd_pkg::CHAR_LO_A + 8'(v - 26);
    if (v < 62) return b64sd_pkg::CHAR_ZERO + 8'(v - 52);
    if (v == b64sd_pkg::SEXTET_PLUS) return b64sd_pkg::CHAR_PLUS;
    return b64sd_pkg::CHAR_SLASH;
  endfunction

  function automatic logic [7:0] blank_char();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? b64sd_pkg::CHAR_SPACE : b64sd_pkg::CHAR_TAB + 8'(r);
  endfunction

  function automatic void add_char(logic [7:0] c);
    if ($urandom_range(0, 9) == 0) msg_chars = {msg_chars, blank_char()};
    msg_chars = {msg_chars, c};
  endfunction

  // A proper encoding of random bytes; now and then unpadded, or with
  // stray characters or whitespace after it.
  function automatic void build_encoded();
    int unsigned n;
    int unsigned take;
    logic [23:0] word;
    bit          drop_pad;
    n        = $urandom_range(1, 12);
    drop_pad = ($urandom_range(0, 4) == 0);
    msg_chars.delete();
    for (int i = 0; i < n; i += 3) begin
      take = (n - i >= 3) ? 3 : n - i;
      word = 24'($urandom);
      if (take == 1) word[15:0] = '0;
      if (take == 2) word[7:0] = '0;
      for (int k = 0; k < 4; k++) begin
        if (k <= take) add_char(char_of_sextet(6'(word >> (18 - 6 * k))));
        else if (!drop_pad) add_char(b64sd_pkg::CHAR_PAD);
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) add_char(char_of_sextet(6'($urandom)));
    end
    if ($urandom_range(0, 7) == 0) msg_chars = {msg_chars, blank_char()};
  endfunction

  function automatic void build_noise();
    int unsigned n;
    n = $urandom_range(1, 10);
    msg_chars.delete();
    repeat (n) begin
      case ($urandom_range(0, 3))
        0, 1: msg_chars = {msg_chars, 8'($urandom_range(0, 255))};
        2: msg_chars = {msg_chars, char_of_sextet(6'($urandom))};
        default: msg_chars = {msg_chars, b64sd_pkg::CHAR_PAD};
      endcase
    end
  endfunction

  initial begin : result_sink
    int unsigned stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = $urandom_range(out_stall_max, 0);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_item);
    end
  end

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    out_ready     = 1'b0;
    in_gap_max    = 0;
    out_stall_max = 0;
    sent_items    = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Extreme sextets, whitespace and high bytes, then messages ending on
    // a pad, on an invalid byte, and with alphabet characters after a pad.
    send_char("A", 1'b0);
    send_char(b64sd_pkg::CHAR_SLASH, 1'b0);
    send_char(b64sd_pkg::CHAR_SPACE, 1'b0);
    send_char(b64sd_pkg::CHAR_PLUS, 1'b0);
    send_char(8'h0A, 1'b0);
    send_char("z", 1'b0);
    send_char("9", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("Z", 1'b1);
    send_char(b64sd_pkg::CHAR_PAD, 1'b1);
    send_char(8'h00, 1'b1);
    send_char("a", 1'b0);
    send_char("b", 1'b0);
    send_char(b64sd_pkg::CHAR_PAD, 1'b0);
    send_char("Q", 1'b0);
    send_char(8'h80, 1'b1);
    send_char(b64sd_pkg::CHAR_TAB, 1'b0);
    send_char(b64sd_pkg::CHAR_CR, 1'b0);
    send_char(8'h0B, 1'b0);
    send_char(8'h0C, 1'b0);
    send_char("0", 1'b0);
    send_char(8'h08, 1'b0);
    send_char(8'h0E, 1'b0);
    send_char("1", 1'b0);
    send_char(b64sd_pkg::CHAR_PAD, 1'b1);

    while (sent_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: begin in_gap_max = 0; out_stall_max = 0; end
        1: begin in_gap_max = 4; out_stall_max = 0; end
        2: begin in_gap_max = 0; out_stall_max = 4; end
        default: begin in_gap_max = 4; out_stall_max = 4; end
      endcase
      if ($urandom_range(0, 3) != 0) build_encoded();
      else build_noise();
      send_message();
    end
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
